// ===== design/xdpt_pkg.sv =====
// ----------------------------------------------------------------------------
// xdpt_pkg: shared types and constants for the XOR distance peer table
// Table sizing, field widths, command codes and sequencer states.
// ----------------------------------------------------------------------------
package xdpt_pkg;

  localparam int TABLE_DEPTH     = 32;
  localparam int ID_BITS         = 64;
  localparam int ADDRESS_BITS    = 48;

  localparam int SLOT_BITS       = $clog2(TABLE_DEPTH);
  localparam int COUNT_BITS      = $clog2(TABLE_DEPTH + 1);
  localparam int PEER_COUNT_BITS = 6;
  localparam int CMD_BITS        = 2;
  localparam int APB_DATA_BITS   = 64;
  localparam int APB_ADDR_BITS   = 4;

  // Distance bits examined per scan cycle by the top-bit finder
  localparam int DIFF_STEP = (ID_BITS + TABLE_DEPTH - 1) / TABLE_DEPTH;

  typedef logic [ID_BITS-1:0]      id_t;
  typedef logic [ADDRESS_BITS-1:0] addr_t;
  typedef logic [SLOT_BITS-1:0]    slot_t;
  typedef logic [COUNT_BITS-1:0]   count_t;

  typedef enum logic [CMD_BITS-1:0] {
    CMD_INSERT   = 2'd0,
    CMD_REMOVE   = 2'd1,
    CMD_NEXT_HOP = 2'd2,
    CMD_CONTAINS = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  // Register map index (bit 3 of the byte address)
  typedef enum logic {
    REG_LOCAL_ID       = 1'b0,
    REG_LOCAL_ENDPOINT = 1'b1
  } reg_idx_t;

  typedef struct packed {
    id_t   local_id;
    addr_t local_endpoint;
  } cfg_t;

endpackage

// ===== design/xdpt_ifs.sv =====
// ----------------------------------------------------------------------------
// xdpt_ifs: valid/ready channels of the peer table
// Command channel and result channel, each with source and sink modports.
// ----------------------------------------------------------------------------
interface xdpt_in_if;
  logic                               valid;
  logic                               ready;
  logic [xdpt_pkg::CMD_BITS-1:0]      command;
  logic [xdpt_pkg::ID_BITS-1:0]       peer_key;
  logic [xdpt_pkg::ADDRESS_BITS-1:0]  peer_address;
  logic [xdpt_pkg::ID_BITS-1:0]       excluded_id;

  modport source (output valid, output command, output peer_key,
                  output peer_address, output excluded_id, input ready);
  modport sink   (input valid, input command, input peer_key,
                  input peer_address, input excluded_id, output ready);
endinterface

interface xdpt_out_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 hit;
  logic                                 table_full;
  logic [xdpt_pkg::ID_BITS-1:0]         hop_id;
  logic [xdpt_pkg::ADDRESS_BITS-1:0]    hop_address;
  logic                                 hop_is_local;
  logic [xdpt_pkg::ID_BITS-1:0]         refill_target;
  logic [xdpt_pkg::PEER_COUNT_BITS-1:0] peer_count;

  modport source (output valid, output hit, output table_full, output hop_id,
                  output hop_address, output hop_is_local, output refill_target,
                  output peer_count, input ready);
  modport sink   (input valid, input hit, input table_full, input hop_id,
                  input hop_address, input hop_is_local, input refill_target,
                  input peer_count, output ready);
endinterface

// ===== design/xor_distance_peer_table_core.sv =====
// ----------------------------------------------------------------------------
// xor_distance_peer_table_core: XOR distance peer table, top level
// Slot table of peers with insert, remove, contains and next-hop lookup.
//
//   port     dir   kind          carries
//   in_ch    in    valid/ready   command, peer_key, peer_address, excluded_id
//   out_ch   out   valid/ready   hit, table_full, hop, refill_target, count
//   p*       in    APB, 64 bit   local_id at 0x0, local_endpoint at 0x8
//
// Each item is accepted, then scanned one slot per cycle through the single
// registered memory read port; the result is then formed in the finish
// state. A new item is taken while the previous result waits.
// Reset (synchronous, rst_n low) clears all valid bits and the count at once.
// A stalled output holds the sequencer in its final cycle.
// ----------------------------------------------------------------------------
module xor_distance_peer_table_core (
  input  logic                               clk,
  input  logic                               rst_n,
  xdpt_in_if.sink                            in_ch,
  xdpt_out_if.source                         out_ch,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [xdpt_pkg::APB_ADDR_BITS-1:0] paddr,
  input  logic [xdpt_pkg::APB_DATA_BITS-1:0] pwdata,
  output logic [xdpt_pkg::APB_DATA_BITS-1:0] prdata,
  output logic                               pready
);

  xdpt_pkg::cfg_t cfg;

  // configuration registers
  xdpt_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // table and sequencer
  xdpt_engine u_engine (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

endmodule

// ===== design/xdpt_cfg.sv =====
// ----------------------------------------------------------------------------
// xdpt_cfg: APB register file
// Holds the local id and local endpoint; 64-bit registers at 8-byte stride.
// ----------------------------------------------------------------------------
module xdpt_cfg (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [xdpt_pkg::APB_ADDR_BITS-1:0] paddr,
  input  logic [xdpt_pkg::APB_DATA_BITS-1:0] pwdata,
  output logic [xdpt_pkg::APB_DATA_BITS-1:0] prdata,
  output logic                               pready,
  output xdpt_pkg::cfg_t                     cfg
);

  xdpt_pkg::id_t     local_id_r;
  xdpt_pkg::addr_t   local_endpoint_r;
  xdpt_pkg::reg_idx_t reg_sel;
  logic              wr_en;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  // byte offset within the 8-byte register is ignored
  assign reg_sel = xdpt_pkg::reg_idx_t'(paddr[3]);

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      local_id_r       <= '0;
      local_endpoint_r <= '0;
    end else if (wr_en) begin
      unique case (reg_sel)
        xdpt_pkg::REG_LOCAL_ID:
          local_id_r <= pwdata[xdpt_pkg::ID_BITS-1:0];
        xdpt_pkg::REG_LOCAL_ENDPOINT:
          local_endpoint_r <= pwdata[xdpt_pkg::ADDRESS_BITS-1:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    prdata = '0;
    unique case (reg_sel)
      xdpt_pkg::REG_LOCAL_ID:
        prdata = xdpt_pkg::APB_DATA_BITS'(local_id_r);
      xdpt_pkg::REG_LOCAL_ENDPOINT:
        prdata = xdpt_pkg::APB_DATA_BITS'(local_endpoint_r);
      default: prdata = '0;
    endcase
  end

  assign cfg.local_id       = local_id_r;
  assign cfg.local_endpoint = local_endpoint_r;

endmodule

// ===== design/xdpt_engine.sv =====
// ----------------------------------------------------------------------------
// xdpt_engine: slot scanner and result register
// Sequencer walks all slots once per command through one registered memory
// read port, one key compare and one distance compare, then forms the item.
// ----------------------------------------------------------------------------
module xdpt_engine (
  input  logic             clk,
  input  logic             rst_n,
  input  xdpt_pkg::cfg_t   cfg,
  xdpt_in_if.sink          in_ch,
  xdpt_out_if.source       out_ch
);

  localparam int DEPTH = xdpt_pkg::TABLE_DEPTH;
  localparam int IDW   = xdpt_pkg::ID_BITS;

  // slot storage (no reset; guarded by valid bits)
  xdpt_pkg::id_t   id_mem   [DEPTH];
  xdpt_pkg::addr_t addr_mem [DEPTH];

  xdpt_pkg::state_t state_r, state_nxt;

  // latched command
  xdpt_pkg::cmd_t  cmd_r;
  xdpt_pkg::id_t   key_r;
  xdpt_pkg::addr_t ins_addr_r;
  xdpt_pkg::id_t   excl_r;

  // scan control
  xdpt_pkg::count_t cnt_r;
  logic             proc_en_r;
  xdpt_pkg::slot_t  proc_idx_r;
  xdpt_pkg::id_t    rd_id_r;
  xdpt_pkg::addr_t  rd_addr_r;

  // table state
  logic [DEPTH-1:0] valid_r;
  xdpt_pkg::count_t count_r;

  // scan results
  logic             found_r;
  logic             free_found_r;
  xdpt_pkg::slot_t  free_idx_r;
  logic             rm_hit_r;
  logic             have_r;
  logic             pick_r;
  xdpt_pkg::id_t    best_r;
  xdpt_pkg::id_t    hop_id_r;
  xdpt_pkg::addr_t  hop_addr_r;

  // top-bit finder for the refill target
  xdpt_pkg::id_t    diff_r, diff_nxt;
  xdpt_pkg::id_t    mask_r, mask_nxt;
  xdpt_pkg::id_t    flip_r, flip_nxt;
  logic             flip_found_r, flip_found_nxt;

  // output register
  logic                                 out_valid_r;
  logic                                 out_hit_r;
  logic                                 out_full_r;
  xdpt_pkg::id_t                        out_hop_id_r;
  xdpt_pkg::addr_t                      out_hop_addr_r;
  logic                                 out_local_r;
  xdpt_pkg::id_t                        out_refill_r;
  logic [xdpt_pkg::PEER_COUNT_BITS-1:0] out_count_r;

  logic            accept;
  logic            fire;
  logic            scan_done;
  logic            slot_v;
  logic            key_match;
  xdpt_pkg::id_t   slot_dist;
  logic            take;
  logic            ins_ok;
  xdpt_pkg::count_t count_after;

  assign in_ch.ready = (state_r == xdpt_pkg::ST_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign fire        = !out_valid_r || out_ch.ready;
  assign scan_done   = (cnt_r == xdpt_pkg::COUNT_BITS'(DEPTH));

  // per-slot compare unit
  assign slot_v    = proc_en_r && valid_r[proc_idx_r];
  assign key_match = slot_v && (rd_id_r == key_r);
  assign slot_dist = rd_id_r ^ key_r;
  assign take      = slot_v && (rd_id_r != excl_r) && (!have_r || (slot_dist < best_r));

  // insert outcome
  assign ins_ok      = (cmd_r == xdpt_pkg::CMD_INSERT) && !found_r && free_found_r;
  assign count_after = count_r + xdpt_pkg::COUNT_BITS'(ins_ok);

  // top-bit finder step: DIFF_STEP distance bits per cycle, most significant first
  always_comb begin
    flip_nxt       = flip_r;
    flip_found_nxt = flip_found_r;
    for (int j = 0; j < xdpt_pkg::DIFF_STEP; j++) begin
      if (!flip_found_nxt && diff_r[IDW-1-j]) begin
        flip_nxt       = mask_r >> j;
        flip_found_nxt = 1'b1;
      end
    end
    diff_nxt = diff_r << xdpt_pkg::DIFF_STEP;
    mask_nxt = mask_r >> xdpt_pkg::DIFF_STEP;
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      xdpt_pkg::ST_IDLE:   if (accept) state_nxt = xdpt_pkg::ST_SCAN;
      xdpt_pkg::ST_SCAN:   if (scan_done) state_nxt = xdpt_pkg::ST_FINISH;
      xdpt_pkg::ST_FINISH: if (fire) state_nxt = xdpt_pkg::ST_IDLE;
      default:             state_nxt = xdpt_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= xdpt_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // slot memory: one read per scan cycle, one write on insert
  always_ff @(posedge clk) begin
    rd_id_r   <= id_mem[cnt_r[xdpt_pkg::SLOT_BITS-1:0]];
    rd_addr_r <= addr_mem[cnt_r[xdpt_pkg::SLOT_BITS-1:0]];
    if (state_r == xdpt_pkg::ST_FINISH && fire && ins_ok) begin
      id_mem[free_idx_r]   <= key_r;
      addr_mem[free_idx_r] <= ins_addr_r;
    end
  end

  // valid bits and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      count_r <= '0;
    end else if (state_r == xdpt_pkg::ST_SCAN) begin
      if (cmd_r == xdpt_pkg::CMD_REMOVE && key_match) begin
        valid_r[proc_idx_r] <= 1'b0;
        if (count_r != '0) count_r <= count_r - xdpt_pkg::COUNT_BITS'(1);
      end
    end else if (state_r == xdpt_pkg::ST_FINISH && fire && ins_ok) begin
      valid_r[free_idx_r] <= 1'b1;
      count_r             <= count_after;
    end
  end

  // scan counter and read pipeline control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      proc_en_r <= 1'b0;
      cnt_r     <= '0;
    end else if (accept) begin
      proc_en_r <= 1'b0;
      cnt_r     <= '0;
    end else if (state_r == xdpt_pkg::ST_SCAN) begin
      proc_en_r <= !scan_done;
      if (!scan_done) cnt_r <= cnt_r + xdpt_pkg::COUNT_BITS'(1);
    end else begin
      proc_en_r <= 1'b0;
    end
  end

  // command latch and scan accumulators
  always_ff @(posedge clk) begin
    proc_idx_r <= cnt_r[xdpt_pkg::SLOT_BITS-1:0];
    if (accept) begin
      cmd_r        <= xdpt_pkg::cmd_t'(in_ch.command);
      key_r        <= in_ch.peer_key;
      ins_addr_r   <= in_ch.peer_address;
      excl_r       <= in_ch.excluded_id;
      found_r      <= 1'b0;
      free_found_r <= 1'b0;
      free_idx_r   <= '0;
      rm_hit_r     <= 1'b0;
      have_r       <= (cfg.local_id != in_ch.excluded_id);
      pick_r       <= 1'b0;
      best_r       <= cfg.local_id ^ in_ch.peer_key;
      diff_r       <= cfg.local_id ^ in_ch.peer_key;
      mask_r       <= {1'b1, {(IDW-1){1'b0}}};
      flip_r       <= '0;
      flip_found_r <= 1'b0;
    end else if (state_r == xdpt_pkg::ST_SCAN) begin
      diff_r       <= diff_nxt;
      mask_r       <= mask_nxt;
      flip_r       <= flip_nxt;
      flip_found_r <= flip_found_nxt;
      if (key_match) begin
        found_r  <= 1'b1;
        rm_hit_r <= 1'b1;
      end
      // lowest free slot
      if (proc_en_r && !valid_r[proc_idx_r] && !free_found_r) begin
        free_found_r <= 1'b1;
        free_idx_r   <= proc_idx_r;
      end
      // nearest candidate so far
      if (cmd_r == xdpt_pkg::CMD_NEXT_HOP && take) begin
        have_r     <= 1'b1;
        pick_r     <= 1'b1;
        best_r     <= slot_dist;
        hop_id_r   <= rd_id_r;
        hop_addr_r <= rd_addr_r;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == xdpt_pkg::ST_FINISH && fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == xdpt_pkg::ST_FINISH && fire) begin
      out_hit_r      <= 1'b0;
      out_full_r     <= 1'b0;
      out_hop_id_r   <= '0;
      out_hop_addr_r <= '0;
      out_local_r    <= 1'b0;
      out_refill_r   <= '0;
      out_count_r    <= xdpt_pkg::PEER_COUNT_BITS'(count_after);
      unique case (cmd_r)
        xdpt_pkg::CMD_INSERT: begin
          out_hit_r  <= ins_ok;
          out_full_r <= !found_r && !free_found_r;
        end
        xdpt_pkg::CMD_REMOVE: begin
          out_hit_r <= rm_hit_r;
          if (rm_hit_r) out_refill_r <= cfg.local_id ^ flip_r;
        end
        xdpt_pkg::CMD_NEXT_HOP: begin
          out_hop_id_r   <= pick_r ? hop_id_r : cfg.local_id;
          out_hop_addr_r <= pick_r ? hop_addr_r : cfg.local_endpoint;
          out_local_r    <= !pick_r;
        end
        xdpt_pkg::CMD_CONTAINS: out_hit_r <= found_r;
        default: ;
      endcase
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.hit           = out_hit_r;
  assign out_ch.table_full    = out_full_r;
  assign out_ch.hop_id        = out_hop_id_r;
  assign out_ch.hop_address   = out_hop_addr_r;
  assign out_ch.hop_is_local  = out_local_r;
  assign out_ch.refill_target = out_refill_r;
  assign out_ch.peer_count    = out_count_r;

  // count tracks the valid bits
  a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_r) == count_r)
    else $error("peer count differs from number of valid slots");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= xdpt_pkg::COUNT_BITS'(DEPTH))
    else $error("peer count above table depth");

  a_scan_start: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == xdpt_pkg::ST_SCAN) && (cnt_r == '0) && !proc_en_r)
    else $error("scan did not start at slot zero");

  a_full_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_full_r |-> !out_hit_r && !out_local_r && (out_refill_r == '0))
    else $error("dropped insert reported other outcomes");

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == xdpt_pkg::ST_FINISH) && fire |=> out_valid_r)
    else $error("finished item not presented");

endmodule
